// ===== design/qvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// shared widths, payload types and rounding constants for the quaternion
// vector rotation pipeline
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int IN_W    = 16;
	localparam int FRAC_W  = 14;
	localparam int PROD1_W = 2 * IN_W;
	localparam int SUM1_W  = PROD1_W + 1;
	localparam int MID_W   = 19;
	localparam int PROD2_W = IN_W + MID_W;
	localparam int SUM2_W  = PROD2_W + 1;
	localparam int RES_W   = SUM2_W - FRAC_W;
	localparam int OUT_W   = 18;
	localparam int N_PROD  = 12;
	localparam int ROUND_HALF = 1 << (FRAC_W - 1);

	localparam int IN_DATA_W  = 7 * IN_W;
	localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

	typedef logic signed [IN_W-1:0]    comp_t;
	typedef logic signed [PROD1_W-1:0] prod1_t;
	typedef logic signed [SUM1_W-1:0]  sum1_t;
	typedef logic signed [MID_W-1:0]   mid_t;
	typedef logic signed [PROD2_W-1:0] prod2_t;
	typedef logic signed [SUM2_W-1:0]  sum2_t;
	typedef logic signed [OUT_W-1:0]   rot_t;

	typedef struct packed {
		comp_t w;
		comp_t z;
		comp_t y;
		comp_t x;
	} quat_t;

	typedef struct packed {
		comp_t z;
		comp_t y;
		comp_t x;
	} vec_t;

	// first product, conjugate times pure vector
	typedef struct packed {
		mid_t t3;
		mid_t t2;
		mid_t t1;
		mid_t t0;
	} mid_quat_t;

	typedef struct packed {
		logic saturated;
		rot_t z;
		rot_t y;
		rot_t x;
	} rot_res_t;

endpackage

// ===== design/qvr_first_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_first_product
// two-stage product of the pure vector quaternion with the conjugate:
// multipliers, then three-term sums with half-up rounding
// ----------------------------------------------------------------------------
module qvr_first_product (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qvr_pkg::quat_t     in_quat,
	input  qvr_pkg::vec_t      in_vec,
	output logic               out_valid,
	input  logic               out_ready,
	output qvr_pkg::quat_t     out_quat,
	output qvr_pkg::mid_quat_t out_mid
);

	logic                   valid_s1;
	logic                   valid_s2;
	logic                   en_s1;
	logic                   en_s2;
	qvr_pkg::quat_t         quat_s1;
	qvr_pkg::quat_t         quat_s2;
	qvr_pkg::prod1_t        prod_s1 [qvr_pkg::N_PROD];
	qvr_pkg::mid_quat_t     mid_s2;
	qvr_pkg::prod1_t        prod_d  [qvr_pkg::N_PROD];
	qvr_pkg::sum1_t         sum_d   [4];
	qvr_pkg::mid_quat_t     mid_d;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		prod_d[0]  = qvr_pkg::prod1_t'(in_vec.z) * qvr_pkg::prod1_t'(in_quat.y);
		prod_d[1]  = qvr_pkg::prod1_t'(in_vec.y) * qvr_pkg::prod1_t'(in_quat.z);
		prod_d[2]  = qvr_pkg::prod1_t'(in_vec.x) * qvr_pkg::prod1_t'(in_quat.w);
		prod_d[3]  = qvr_pkg::prod1_t'(in_vec.z) * qvr_pkg::prod1_t'(in_quat.x);
		prod_d[4]  = qvr_pkg::prod1_t'(in_vec.x) * qvr_pkg::prod1_t'(in_quat.z);
		prod_d[5]  = qvr_pkg::prod1_t'(in_vec.y) * qvr_pkg::prod1_t'(in_quat.w);
		prod_d[6]  = qvr_pkg::prod1_t'(in_vec.y) * qvr_pkg::prod1_t'(in_quat.x);
		prod_d[7]  = qvr_pkg::prod1_t'(in_vec.x) * qvr_pkg::prod1_t'(in_quat.y);
		prod_d[8]  = qvr_pkg::prod1_t'(in_vec.z) * qvr_pkg::prod1_t'(in_quat.w);
		prod_d[9]  = qvr_pkg::prod1_t'(in_vec.x) * qvr_pkg::prod1_t'(in_quat.x);
		prod_d[10] = qvr_pkg::prod1_t'(in_vec.y) * qvr_pkg::prod1_t'(in_quat.y);
		prod_d[11] = qvr_pkg::prod1_t'(in_vec.z) * qvr_pkg::prod1_t'(in_quat.z);
	end

	// sums carry the rounding half, the slice is the floor shift
	always_comb begin
		sum_d[0] = qvr_pkg::sum1_t'(prod_s1[1]) + qvr_pkg::sum1_t'(prod_s1[2])
			- qvr_pkg::sum1_t'(prod_s1[0]) + qvr_pkg::sum1_t'(qvr_pkg::ROUND_HALF);
		sum_d[1] = qvr_pkg::sum1_t'(prod_s1[3]) + qvr_pkg::sum1_t'(prod_s1[5])
			- qvr_pkg::sum1_t'(prod_s1[4]) + qvr_pkg::sum1_t'(qvr_pkg::ROUND_HALF);
		sum_d[2] = qvr_pkg::sum1_t'(prod_s1[7]) + qvr_pkg::sum1_t'(prod_s1[8])
			- qvr_pkg::sum1_t'(prod_s1[6]) + qvr_pkg::sum1_t'(qvr_pkg::ROUND_HALF);
		sum_d[3] = qvr_pkg::sum1_t'(prod_s1[9]) + qvr_pkg::sum1_t'(prod_s1[10])
			+ qvr_pkg::sum1_t'(prod_s1[11]) + qvr_pkg::sum1_t'(qvr_pkg::ROUND_HALF);
		mid_d.t0 = qvr_pkg::mid_t'(sum_d[0][qvr_pkg::FRAC_W +: qvr_pkg::MID_W]);
		mid_d.t1 = qvr_pkg::mid_t'(sum_d[1][qvr_pkg::FRAC_W +: qvr_pkg::MID_W]);
		mid_d.t2 = qvr_pkg::mid_t'(sum_d[2][qvr_pkg::FRAC_W +: qvr_pkg::MID_W]);
		mid_d.t3 = qvr_pkg::mid_t'(sum_d[3][qvr_pkg::FRAC_W +: qvr_pkg::MID_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			quat_s1 <= in_quat;
			prod_s1 <= prod_d;
		end
		if (en_s2) begin
			quat_s2 <= quat_s1;
			mid_s2  <= mid_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_quat  = quat_s2;
	assign out_mid   = mid_s2;

endmodule

// ===== design/qvr_second_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_second_product
// two-stage product of the quaternion with the intermediate result:
// multipliers, then four-term sums, half-up rounding and 18-bit saturation
// ----------------------------------------------------------------------------
module qvr_second_product (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qvr_pkg::quat_t     in_quat,
	input  qvr_pkg::mid_quat_t in_mid,
	output logic               out_valid,
	input  logic               out_ready,
	output qvr_pkg::rot_res_t  out_res
);

	typedef logic signed [qvr_pkg::RES_W-1:0] res_t;

	typedef struct packed {
		logic          clip;
		qvr_pkg::rot_t val;
	} sat_t;

	logic              valid_s3;
	logic              valid_s4;
	logic              en_s3;
	logic              en_s4;
	qvr_pkg::prod2_t   prod_s3 [qvr_pkg::N_PROD];
	qvr_pkg::rot_res_t res_s4;
	qvr_pkg::prod2_t   prod_d  [qvr_pkg::N_PROD];
	qvr_pkg::sum2_t    sum_d   [3];
	sat_t              sat_d   [3];
	qvr_pkg::rot_res_t res_d;

	function automatic sat_t sat18(input qvr_pkg::sum2_t s);
		res_t r;
		sat_t o;
		r = res_t'(s[qvr_pkg::FRAC_W +: qvr_pkg::RES_W]);
		if (r[qvr_pkg::RES_W-1:qvr_pkg::OUT_W-1] ==
			{(qvr_pkg::RES_W-qvr_pkg::OUT_W+1){r[qvr_pkg::OUT_W-1]}}) begin
			o.clip = 1'b0;
			o.val  = qvr_pkg::rot_t'(r[qvr_pkg::OUT_W-1:0]);
		end else begin
			o.clip = 1'b1;
			o.val  = {r[qvr_pkg::RES_W-1], {(qvr_pkg::OUT_W-1){~r[qvr_pkg::RES_W-1]}}};
		end
		return o;
	endfunction

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		prod_d[0]  = qvr_pkg::prod2_t'(in_quat.w) * qvr_pkg::prod2_t'(in_mid.t0);
		prod_d[1]  = qvr_pkg::prod2_t'(in_quat.z) * qvr_pkg::prod2_t'(in_mid.t1);
		prod_d[2]  = qvr_pkg::prod2_t'(in_quat.y) * qvr_pkg::prod2_t'(in_mid.t2);
		prod_d[3]  = qvr_pkg::prod2_t'(in_quat.x) * qvr_pkg::prod2_t'(in_mid.t3);
		prod_d[4]  = qvr_pkg::prod2_t'(in_quat.z) * qvr_pkg::prod2_t'(in_mid.t0);
		prod_d[5]  = qvr_pkg::prod2_t'(in_quat.w) * qvr_pkg::prod2_t'(in_mid.t1);
		prod_d[6]  = qvr_pkg::prod2_t'(in_quat.x) * qvr_pkg::prod2_t'(in_mid.t2);
		prod_d[7]  = qvr_pkg::prod2_t'(in_quat.y) * qvr_pkg::prod2_t'(in_mid.t3);
		prod_d[8]  = qvr_pkg::prod2_t'(in_quat.y) * qvr_pkg::prod2_t'(in_mid.t0);
		prod_d[9]  = qvr_pkg::prod2_t'(in_quat.x) * qvr_pkg::prod2_t'(in_mid.t1);
		prod_d[10] = qvr_pkg::prod2_t'(in_quat.w) * qvr_pkg::prod2_t'(in_mid.t2);
		prod_d[11] = qvr_pkg::prod2_t'(in_quat.z) * qvr_pkg::prod2_t'(in_mid.t3);
	end

	always_comb begin
		sum_d[0] = qvr_pkg::sum2_t'(prod_s3[0]) + qvr_pkg::sum2_t'(prod_s3[1])
			- qvr_pkg::sum2_t'(prod_s3[2]) + qvr_pkg::sum2_t'(prod_s3[3])
			+ qvr_pkg::sum2_t'(qvr_pkg::ROUND_HALF);
		sum_d[1] = qvr_pkg::sum2_t'(prod_s3[5]) + qvr_pkg::sum2_t'(prod_s3[6])
			- qvr_pkg::sum2_t'(prod_s3[4]) + qvr_pkg::sum2_t'(prod_s3[7])
			+ qvr_pkg::sum2_t'(qvr_pkg::ROUND_HALF);
		sum_d[2] = qvr_pkg::sum2_t'(prod_s3[8]) + qvr_pkg::sum2_t'(prod_s3[10])
			- qvr_pkg::sum2_t'(prod_s3[9]) + qvr_pkg::sum2_t'(prod_s3[11])
			+ qvr_pkg::sum2_t'(qvr_pkg::ROUND_HALF);
		sat_d[0] = sat18(sum_d[0]);
		sat_d[1] = sat18(sum_d[1]);
		sat_d[2] = sat18(sum_d[2]);
		res_d.x         = sat_d[0].val;
		res_d.y         = sat_d[1].val;
		res_d.z         = sat_d[2].val;
		res_d.saturated = sat_d[0].clip | sat_d[1].clip | sat_d[2].clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= in_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= prod_d;
		end
		if (en_s4) begin
			res_s4 <= res_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_res   = res_s4;

endmodule

// ===== design/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates a 3-vector by a Q2.14 quaternion, conj(q) * v * q, rounded and
// saturated to signed 18 bits
// ----------------------------------------------------------------------------
//  channel  direction  tdata                                   tuser
//  s_axis   in         quat_x/y/z/w, vec_x/y/z (16 b each)     -
//  m_axis   out        rot_x/y/z (18 b each, 2 b zero pad)     saturated
//
//  four register stages, one transaction per cycle while m_axis is not stalled
//  the two multiplier stages hold twelve multipliers each
//  reset clears the stage valid bits only
//  each stage holds while the one after it is full and stalled, so bubbles
//  close up and a waiting result blocks new input only once all four stages
//  are full
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
	input  logic [qvr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// rot_x, rot_y, rot_z, zero pad
	output logic [qvr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// saturated
	output logic                              m_axis_tuser
);

	qvr_pkg::quat_t     in_quat;
	qvr_pkg::vec_t      in_vec;
	logic               mid_valid;
	logic               mid_ready;
	qvr_pkg::quat_t     mid_quat;
	qvr_pkg::mid_quat_t mid_val;
	qvr_pkg::rot_res_t  res;

	assign in_quat.x = qvr_pkg::comp_t'(s_axis_tdata[0*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_quat.y = qvr_pkg::comp_t'(s_axis_tdata[1*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_quat.z = qvr_pkg::comp_t'(s_axis_tdata[2*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_quat.w = qvr_pkg::comp_t'(s_axis_tdata[3*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_vec.x  = qvr_pkg::comp_t'(s_axis_tdata[4*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_vec.y  = qvr_pkg::comp_t'(s_axis_tdata[5*qvr_pkg::IN_W +: qvr_pkg::IN_W]);
	assign in_vec.z  = qvr_pkg::comp_t'(s_axis_tdata[6*qvr_pkg::IN_W +: qvr_pkg::IN_W]);

	qvr_first_product u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_quat   (in_quat),
		.in_vec    (in_vec),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_quat  (mid_quat),
		.out_mid   (mid_val)
	);

	qvr_second_product u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_quat   (mid_quat),
		.in_mid    (mid_val),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {{(qvr_pkg::OUT_DATA_W - 3*qvr_pkg::OUT_W){1'b0}},
		res.z, res.y, res.x};
	assign m_axis_tuser = res.saturated;

endmodule
